@@ hw/rtl/etf_pkg.sv @@
// types, constants and helpers shared by the escape-time fractal pixel engine
// no dependencies
`timescale 1ns / 1ps

package etf_pkg;

  localparam int FRAC_BITS = 28;
  localparam int ADDR_W    = 5;

  localparam logic [1:0] MODE_SPIDER = 2'd0;
  localparam logic [1:0] MODE_JULIA  = 2'd1;
  localparam logic [1:0] MODE_MANDEL = 2'd2;

  localparam logic [7:0] LIMIT_ESCAPE = 8'd42;
  localparam logic [7:0] LIMIT_JULIA  = 8'd128;

  // 4.0 in Q8.56
  localparam logic [63:0] ESCAPE_BOUND = 64'h0400_0000_0000_0000;

  // register indexes
  localparam logic [2:0] REG_MODE      = 3'd0;
  localparam logic [2:0] REG_STEP_RE   = 3'd1;
  localparam logic [2:0] REG_STEP_IM   = 3'd2;
  localparam logic [2:0] REG_ORIGIN_RE = 3'd3;
  localparam logic [2:0] REG_ORIGIN_IM = 3'd4;
  localparam logic [2:0] REG_JULIA_RE  = 3'd5;
  localparam logic [2:0] REG_JULIA_IM  = 3'd6;

  localparam logic [1:0]  RST_MODE      = MODE_MANDEL;
  localparam logic [31:0] RST_STEP_RE   = 32'd1048576;
  localparam logic [31:0] RST_STEP_IM   = 32'd1048576;
  localparam logic [31:0] RST_ORIGIN_RE = 32'hE000_0000;
  localparam logic [31:0] RST_ORIGIN_IM = 32'hE000_0000;
  localparam logic [31:0] RST_JULIA_RE  = 32'd76504269;
  localparam logic [31:0] RST_JULIA_IM  = 32'd2684355;

  typedef struct packed {
    logic [9:0] pixel_x;
    logic [9:0] pixel_y;
  } in_t;

  typedef struct packed {
    logic [9:0] out_x;
    logic [9:0] out_y;
    logic [7:0] iterations;
  } out_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] step_re;
    logic signed [31:0] step_im;
    logic signed [31:0] origin_re;
    logic signed [31:0] origin_im;
    logic signed [31:0] julia_re;
    logic signed [31:0] julia_im;
  } cfg_t;

  typedef enum logic [3:0] {
    DP_IDLE,
    DP_LOAD,
    DP_MAPX,
    DP_MAPY,
    DP_MAPI,
    DP_SQR,
    DP_SQI,
    DP_CROSS,
    DP_UPD
  } dp_cmd_t;

  typedef struct packed {
    logic first;
    logic escape;
    logic last;
  } dp_status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MAPX,
    S_MAPY,
    S_MAPI,
    S_SQR,
    S_SQI,
    S_CROSS,
    S_UPD,
    S_DONE
  } state_t;

  // clamp to the Q4.28 range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

endpackage

@@ hw/rtl/etf_regs.sv @@
// configuration register file behind the apb-style port
// depends on etf_pkg
`timescale 1ns / 1ps

module etf_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [etf_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output etf_pkg::cfg_t               cfg
);
  import etf_pkg::*;

  logic [2:0] idx;
  logic       wr;

  assign idx    = paddr[4:2];
  assign wr     = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode      <= RST_MODE;
      cfg.step_re   <= RST_STEP_RE;
      cfg.step_im   <= RST_STEP_IM;
      cfg.origin_re <= RST_ORIGIN_RE;
      cfg.origin_im <= RST_ORIGIN_IM;
      cfg.julia_re  <= RST_JULIA_RE;
      cfg.julia_im  <= RST_JULIA_IM;
    end else if (wr) begin
      case (idx)
        REG_MODE:      cfg.mode      <= pwdata[1:0];
        REG_STEP_RE:   cfg.step_re   <= pwdata;
        REG_STEP_IM:   cfg.step_im   <= pwdata;
        REG_ORIGIN_RE: cfg.origin_re <= pwdata;
        REG_ORIGIN_IM: cfg.origin_im <= pwdata;
        REG_JULIA_RE:  cfg.julia_re  <= pwdata;
        REG_JULIA_IM:  cfg.julia_im  <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MODE:      prdata = {30'd0, cfg.mode};
      REG_STEP_RE:   prdata = cfg.step_re;
      REG_STEP_IM:   prdata = cfg.step_im;
      REG_ORIGIN_RE: prdata = cfg.origin_re;
      REG_ORIGIN_IM: prdata = cfg.origin_im;
      REG_JULIA_RE:  prdata = cfg.julia_re;
      REG_JULIA_IM:  prdata = cfg.julia_im;
      default:       prdata = 32'd0;
    endcase
  end

endmodule

@@ hw/rtl/etf_dp.sv @@
// datapath: shared 32x32 multiplier, z and c registers, iteration counter
// depends on etf_pkg
`timescale 1ns / 1ps

module etf_dp (
  input  logic                clk,
  input  logic                rst,
  input  etf_pkg::dp_cmd_t    cmd,
  input  etf_pkg::cfg_t       cfg,
  input  etf_pkg::in_t        item,
  output etf_pkg::dp_status_t status,
  output etf_pkg::out_t       result
);
  import etf_pkg::*;

  logic [9:0]         px;
  logic [9:0]         py;
  logic signed [31:0] zr, zi, cr, ci;
  logic signed [63:0] prod;
  logic signed [63:0] sqr, sqi;
  logic [7:0]         iter;
  logic               first;

  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  logic signed [31:0] map_val;
  logic signed [63:0] diff;
  logic signed [31:0] nr, ni;
  logic [63:0]        mag;
  logic               julia, spider;
  logic [7:0]         limit;

  assign julia  = (cfg.mode == MODE_JULIA);
  assign spider = (cfg.mode != MODE_JULIA) && (cfg.mode != MODE_MANDEL);
  assign limit  = julia ? LIMIT_JULIA : LIMIT_ESCAPE;

  always_comb begin
    case (cmd)
      DP_MAPX: begin
        mul_a = {22'd0, px};
        mul_b = cfg.step_re;
      end
      DP_MAPY: begin
        mul_a = {22'd0, py};
        mul_b = cfg.step_im;
      end
      DP_SQR: begin
        mul_a = zr;
        mul_b = zr;
      end
      DP_SQI: begin
        mul_a = zi;
        mul_b = zi;
      end
      default: begin
        mul_a = zr;
        mul_b = zi;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // mapping: origin plus the product held from the previous cycle
  always_comb begin
    if (cmd == DP_MAPI) begin
      map_val = sat32(64'(cfg.origin_im) + prod);
    end else begin
      map_val = sat32(64'(cfg.origin_re) + prod);
    end
  end

  // round update from the squares and the cross product
  assign diff = sqr - sqi;
  assign nr   = sat32((diff >>> FRAC_BITS) + 64'(cr));
  assign ni   = sat32((prod >>> (FRAC_BITS - 1)) + 64'(ci));

  // prod holds zi squared during the cross cycle
  assign mag = $unsigned(sqr) + $unsigned(prod);

  assign status.first  = first;
  assign status.escape = (mag > ESCAPE_BOUND);
  assign status.last   = ((iter + 8'd1) == limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      iter  <= 8'd0;
      first <= 1'b1;
    end else begin
      case (cmd)
        DP_LOAD: begin
          iter  <= 8'd0;
          first <= 1'b1;
        end
        DP_CROSS: begin
          first <= 1'b0;
          if (!first && !status.escape) begin
            iter <= iter + 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd != DP_IDLE && cmd != DP_LOAD) begin
      prod <= mul_p;
    end
    case (cmd)
      DP_LOAD: begin
        px <= item.pixel_x;
        py <= item.pixel_y;
        zr <= 32'sd0;
        zi <= 32'sd0;
        cr <= cfg.julia_re;
        ci <= cfg.julia_im;
      end
      DP_MAPY: begin
        if (julia) zr <= map_val;
        else       cr <= map_val;
      end
      DP_MAPI: begin
        if (julia) zi <= map_val;
        else       ci <= map_val;
      end
      DP_SQR: begin
        if (spider && !first) begin
          cr <= sat32(64'(cr >>> 1) + 64'(zr));
          ci <= sat32(64'(ci >>> 1) + 64'(zi));
        end
      end
      DP_SQI: begin
        sqr <= prod;
      end
      DP_CROSS: begin
        sqi <= prod;
      end
      DP_UPD: begin
        zr <= nr;
        zi <= ni;
      end
      default: ;
    endcase
  end

  assign result.out_x      = px;
  assign result.out_y      = py;
  assign result.iterations = (julia && iter == LIMIT_JULIA) ? 8'd0 : iter;

endmodule

@@ hw/rtl/etf_ctrl.sv @@
// controller state machine sequencing mapping and iteration rounds
// depends on etf_pkg
`timescale 1ns / 1ps

module etf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  etf_pkg::dp_status_t status,
  output etf_pkg::dp_cmd_t    cmd,
  output logic                busy,
  output logic                done
);
  import etf_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    case (state)
      S_IDLE, S_DONE: state_next = start ? S_MAPX : S_IDLE;
      S_MAPX:  state_next = S_MAPY;
      S_MAPY:  state_next = S_MAPI;
      S_MAPI:  state_next = S_SQR;
      S_SQR:   state_next = S_SQI;
      S_SQI:   state_next = S_CROSS;
      S_CROSS: begin
        if (status.first) begin
          state_next = S_UPD;
        end else if (status.escape || status.last) begin
          state_next = S_DONE;
        end else begin
          state_next = S_UPD;
        end
      end
      S_UPD:   state_next = S_SQR;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    done = 1'b0;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        cmd  = start ? DP_LOAD : DP_IDLE;
      end
      S_DONE: begin
        busy = 1'b0;
        done = 1'b1;
        cmd  = start ? DP_LOAD : DP_IDLE;
      end
      S_MAPX:  cmd = DP_MAPX;
      S_MAPY:  cmd = DP_MAPY;
      S_MAPI:  cmd = DP_MAPI;
      S_SQR:   cmd = DP_SQR;
      S_SQI:   cmd = DP_SQI;
      S_CROSS: cmd = DP_CROSS;
      S_UPD:   cmd = DP_UPD;
      default: cmd = DP_IDLE;
    endcase
  end

endmodule

@@ hw/rtl/escape_time_fractal_pixel.sv @@
// escape-time fractal pixel engine, top level; depends on etf_pkg, etf_regs, etf_ctrl, etf_dp
// one pixel at a time: the next pixel is taken no earlier than its predecessor's result word
// a round is two squares and the cross product on the single shared 32x32 multiplier,
// then the update
// reset: synchronous, restores register defaults; results cannot be stalled
`timescale 1ns / 1ps

module escape_time_fractal_pixel (
  input  logic                        clk,
  input  logic                        rst,
  // command side
  input  logic                        start,
  output logic                        busy,
  input  etf_pkg::in_t                item,
  // result side
  output logic                        done,
  output etf_pkg::out_t               result,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [etf_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import etf_pkg::*;

  cfg_t       cfg;
  dp_cmd_t    cmd;
  dp_status_t status;

  // register file: mode, steps, origin and julia constant
  etf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: load, map x and y, then rounds of square, square, cross, update
  // busy drops in the result cycle so the next word can be taken straight away
  etf_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy),
    .done   (done)
  );

  // arithmetic: shared multiplier, saturating adds, escape compare in q8.56
  etf_dp u_dp (
    .clk    (clk),
    .rst    (rst),
    .cmd    (cmd),
    .cfg    (cfg),
    .item   (item),
    .status (status),
    .result (result)
  );

endmodule

@@ dv/escape_time_fractal_pixel_test.sv @@
`timescale 1ns / 1ps
// self-checking bench for the escape-time fractal pixel engine: directed views, then random views
// predicts every result word with a cycle-free copy of the iteration; depends on etf_pkg and the rtl

module escape_time_fractal_pixel_test;
  import etf_pkg::*;

  // the limit covers the slowest pixel, a julia pixel run to its limit, plus the sender's idle gaps
  localparam int CYCLE_LIMIT     = 8_000_000;
  localparam int SETTLE_CYCLES   = 600;
  localparam int RANDOM_VIEWS    = 20;
  localparam int PIXELS_PER_VIEW = 100;
  localparam int MAX_GAP         = 200;

  // mode code with no meaning of its own, behaves as spider
  localparam logic [1:0] MODE_SPARE = 2'd3;
  // register slot past the last register, writes to it are dropped
  localparam logic [2:0] REG_SPARE  = 3'd7;

  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;

  logic              clk     = 1'b0;
  logic              rst     = 1'b1;
  logic              start   = 1'b0;
  logic              busy;
  in_t               item    = '0;
  logic              done;
  out_t              result;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [31:0]       pwdata  = '0;
  logic [31:0]       prdata;
  logic              pready;

  in_t  pixel_queue[$];   // pixels waiting to be offered
  out_t awaited[$];       // predicted result words, oldest first
  cfg_t view;             // bench copy of the register file
  logic taken      = 1'b0;
  int   hold_off   = 0;
  int   gap_pct    = 32;
  int   bad_words  = 0;
  int   cycle_count = 0;

  escape_time_fractal_pixel i_dut (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .busy    (busy),
    .item    (item),
    .done    (done),
    .result  (result),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // clamp to the q4.28 range
  function automatic longint clamp_q428(input longint v);
    if (v > Q_MAX) begin
      return Q_MAX;
    end
    if (v < Q_MIN) begin
      return Q_MIN;
    end
    return v;
  endfunction

  // escape count for one pixel under a given register setting
  function automatic logic [7:0] escape_count(input cfg_t v, input in_t p);
    longint          zr, zi, cr, ci, nr, ni;
    longint unsigned mag;
    int              limit, rounds;
    bit              spider, escaped;
    spider = (v.mode != MODE_JULIA) && (v.mode != MODE_MANDEL);
    // map the pixel: the product is exact, only the sum saturates
    cr = clamp_q428(longint'(v.origin_re) + longint'(p.pixel_x) * longint'(v.step_re));
    ci = clamp_q428(longint'(v.origin_im) + longint'(p.pixel_y) * longint'(v.step_im));
    if (v.mode == MODE_JULIA) begin
      zr    = cr;
      zi    = ci;
      cr    = v.julia_re;
      ci    = v.julia_im;
      limit = LIMIT_JULIA;
    end else begin
      zr    = 0;
      zi    = 0;
      limit = LIMIT_ESCAPE;
    end
    rounds  = 0;
    escaped = 1'b0;
    while (rounds < limit && !escaped) begin
      // arithmetic shift on a signed value rounds toward minus infinity
      nr = clamp_q428(((zr * zr - zi * zi) >>> FRAC_BITS) + cr);
      ni = clamp_q428(((zr * zi) >>> (FRAC_BITS - 1)) + ci);
      zr = nr;
      zi = ni;
      if (spider) begin
        cr = clamp_q428((cr >>> 1) + zr);
        ci = clamp_q428((ci >>> 1) + zi);
      end
      // both squares together reach 2^63 at most, so unsigned 64 bits hold them
      mag = $unsigned(zr * zr) + $unsigned(zi * zi);
      if (mag > ESCAPE_BOUND) begin
        escaped = 1'b1;
      end else begin
        rounds++;
      end
    end
    // julia points that never leave are reported as zero
    if (v.mode == MODE_JULIA && rounds == limit) begin
      rounds = 0;
    end
    return 8'(rounds);
  endfunction

  // a random view: mostly a sensible window on the set, now and then raw 32-bit values
  function automatic cfg_t random_view();
    cfg_t v;
    bit   wild_map, wild_const;
    wild_map   = ($urandom_range(9) < 2);
    wild_const = ($urandom_range(9) < 2);
    v.mode     = 2'($urandom_range(3));
    if (wild_map) begin
      v.step_re   = $urandom;
      v.step_im   = $urandom;
      v.origin_re = $urandom;
      v.origin_im = $urandom;
    end else begin
      // 1024 columns times at most 2^20 spans four units
      v.step_re   = $urandom_range(1 << 20, 1 << 14);
      v.step_im   = $urandom_range(1 << 20, 1 << 14);
      if ($urandom_range(7) == 0) begin
        v.step_re = -v.step_re;
      end
      if ($urandom_range(7) == 0) begin
        v.step_im = -v.step_im;
      end
      v.origin_re = int'($urandom_range(805306368)) - 671088640;
      v.origin_im = int'($urandom_range(671088640)) - 536870912;
    end
    if (wild_const) begin
      v.julia_re = $urandom;
      v.julia_im = $urandom;
    end else begin
      v.julia_re = int'($urandom_range(536870912)) - 268435456;
      v.julia_im = int'($urandom_range(536870912)) - 268435456;
    end
    return v;
  endfunction

  task automatic queue_pixel(input int x, input int y);
    in_t p;
    p.pixel_x = x[9:0];
    p.pixel_y = y[9:0];
    pixel_queue.push_back(p);
  endtask

  // returns once nothing is queued, offered or in flight and the engine is free
  task automatic wait_idle();
    @(posedge clk);
    while (pixel_queue.size() != 0 || start || awaited.size() != 0 || busy) begin
      @(posedge clk);
    end
  endtask

  // setup then access phase; the bus is left in access for a back-to-back write
  task automatic reg_write(input logic [2:0] idx, input logic [31:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
  endtask

  task automatic bus_release();
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_view(input cfg_t v);
    logic [31:0] noise;
    noise = $urandom;
    // only the low two bits of the mode word matter
    reg_write(REG_MODE, {noise[31:2], v.mode});
    reg_write(REG_STEP_RE, v.step_re);
    reg_write(REG_STEP_IM, v.step_im);
    reg_write(REG_ORIGIN_RE, v.origin_re);
    reg_write(REG_ORIGIN_IM, v.origin_im);
    reg_write(REG_JULIA_RE, v.julia_re);
    reg_write(REG_JULIA_IM, v.julia_im);
    bus_release();
  endtask

  // driver: offers queued pixels at the falling edge and holds each one until taken
  always @(negedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else if (start && !taken) begin
      // word still on offer, engine busy
    end else if (hold_off != 0) begin
      start    <= 1'b0;
      hold_off <= hold_off - 1;
    end else if (pixel_queue.size() != 0) begin
      // idle gaps run long enough to end in any part of a pixel's iteration
      if ($urandom_range(99) < gap_pct) begin
        start    <= 1'b0;
        hold_off <= $urandom_range(MAX_GAP, 1);
      end else begin
        start <= 1'b1;
        item  <= pixel_queue.pop_front();
      end
    end else begin
      start <= 1'b0;
    end
  end

  // monitor: tracks register writes, predicts accepted pixels, checks result words
  always @(posedge clk) begin : monitor
    out_t next_word, oldest;
    if (rst) begin
      taken          <= 1'b0;
      view.mode      <= RST_MODE;
      view.step_re   <= RST_STEP_RE;
      view.step_im   <= RST_STEP_IM;
      view.origin_re <= RST_ORIGIN_RE;
      view.origin_im <= RST_ORIGIN_IM;
      view.julia_re  <= RST_JULIA_RE;
      view.julia_im  <= RST_JULIA_IM;
    end else begin
      taken <= start && !busy;
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_MODE:      view.mode      <= pwdata[1:0];
          REG_STEP_RE:   view.step_re   <= pwdata;
          REG_STEP_IM:   view.step_im   <= pwdata;
          REG_ORIGIN_RE: view.origin_re <= pwdata;
          REG_ORIGIN_IM: view.origin_im <= pwdata;
          REG_JULIA_RE:  view.julia_re  <= pwdata;
          REG_JULIA_IM:  view.julia_im  <= pwdata;
          default: ;
        endcase
      end
      // registers only change while idle, so the current view holds for this pixel
      if (start && !busy) begin
        next_word.out_x      = item.pixel_x;
        next_word.out_y      = item.pixel_y;
        next_word.iterations = escape_count(view, item);
        awaited.push_back(next_word);
      end
      if (done) begin
        if (awaited.size() == 0) begin
          bad_words++;
          if (bad_words <= 10) begin
            $display("unexpected word: (%0d, %0d) iterations %0d",
                     result.out_x, result.out_y, result.iterations);
          end
        end else begin
          oldest = awaited.pop_front();
          if (result.out_x !== oldest.out_x || result.out_y !== oldest.out_y ||
              result.iterations !== oldest.iterations) begin
            bad_words++;
            if (bad_words <= 10) begin
              $display("mismatch: expected (%0d, %0d) iterations %0d, got (%0d, %0d) iterations %0d",
                       oldest.out_x, oldest.out_y, oldest.iterations,
                       result.out_x, result.out_y, result.iterations);
            end
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("escape_time_fractal_pixel_test: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    cfg_t v;
    int   ph;
    v.mode      = RST_MODE;
    v.step_re   = RST_STEP_RE;
    v.step_im   = RST_STEP_IM;
    v.origin_re = RST_ORIGIN_RE;
    v.origin_im = RST_ORIGIN_IM;
    v.julia_re  = RST_JULIA_RE;
    v.julia_im  = RST_JULIA_IM;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // reset view untouched: mandelbrot over [-2, 2) on both axes, corners and centre
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);
    queue_pixel(0, 1023);
    queue_pixel(1023, 0);
    queue_pixel(512, 512);    // c = 0, never leaves, full count
    queue_pixel(341, 682);
    wait_idle();

    // spider over the same window
    v.mode = MODE_SPIDER;
    set_view(v);
    queue_pixel(512, 512);
    queue_pixel(400, 600);
    queue_pixel(682, 341);
    wait_idle();

    // julia with the default constant, escapes slowly near the cusp
    v.mode = MODE_JULIA;
    set_view(v);
    queue_pixel(512, 512);
    queue_pixel(0, 0);
    queue_pixel(600, 530);
    wait_idle();

    // julia with a zero constant: the origin stays put, the limit is hit and reads as zero
    v.julia_re = 0;
    v.julia_im = 0;
    set_view(v);
    queue_pixel(512, 512);
    wait_idle();

    // the spare mode code
    v.mode = MODE_SPARE;
    set_view(v);
    queue_pixel(512, 512);
    queue_pixel(300, 700);
    wait_idle();

    // mapping saturates at both rails; the spare register slot must not disturb anything
    v.mode      = MODE_MANDEL;
    v.step_re   = 32'sh7fff_ffff;
    v.step_im   = 32'sh8000_0000;
    v.origin_re = 32'sh7fff_ffff;
    v.origin_im = 32'sh8000_0000;
    set_view(v);
    reg_write(REG_SPARE, $urandom);
    bus_release();
    queue_pixel(1023, 1023);
    queue_pixel(0, 0);
    queue_pixel(1, 1);
    wait_idle();

    // julia constant at the extremes, start point at zero
    v.mode      = MODE_JULIA;
    v.step_re   = 0;
    v.step_im   = 0;
    v.origin_re = 0;
    v.origin_im = 0;
    v.julia_re  = 32'sh8000_0000;
    v.julia_im  = 32'sh7fff_ffff;
    set_view(v);
    queue_pixel(0, 0);
    queue_pixel(1023, 1023);

    // random views; a stretch of them runs with the sender never idle
    for (ph = 0; ph < RANDOM_VIEWS; ph++) begin
      wait_idle();
      set_view(random_view());
      gap_pct = (ph >= 6 && ph < 10) ? 0 : 32;
      repeat (PIXELS_PER_VIEW / 2) begin
        queue_pixel($urandom_range(1023), $urandom_range(1023));
      end
      // now and then hold the rest back until the engine has drained
      if (ph % 5 == 2) begin
        wait_idle();
      end
      repeat (PIXELS_PER_VIEW - PIXELS_PER_VIEW / 2) begin
        queue_pixel($urandom_range(1023), $urandom_range(1023));
      end
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    bad_words += awaited.size();
    if (bad_words == 0) begin
      $display("escape_time_fractal_pixel_test: done, clean");
    end else begin
      $display("escape_time_fractal_pixel_test: done, errors");
    end
    $finish;
  end

endmodule
